FILE: sv/assert_macros.svh
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ECF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define ECF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ecf_pkg.sv
`default_nettype none
package ecf_pkg;

  localparam int unsigned MaxVertices = 8;
  localparam int unsigned VtxW        = $clog2(MaxVertices);
  localparam int unsigned ListCap     = MaxVertices + 1;
  localparam int unsigned LenW        = $clog2(ListCap + 1);
  localparam int unsigned ListSlots   = 2 ** LenW;
  localparam int unsigned NbrDepth    = MaxVertices * ListSlots;
  localparam int unsigned MaxResults  = (MaxVertices * (MaxVertices + 1)) / 2 + 1;
  localparam int unsigned SpW         = $clog2(MaxResults + 1);
  localparam int unsigned StkW        = VtxW + LenW;
  localparam int unsigned VcW         = 4;
  localparam int unsigned UsedAw      = 2 * VtxW;
  localparam int unsigned UsedDepth   = 2 ** UsedAw;
  localparam int unsigned ClrW        = UsedAw + 1;

  typedef enum logic [1:0] {
    ModeAdd   = 2'd0,
    ModeFind  = 2'd1,
    ModeClear = 2'd2
  } mode_e;

endpackage
`default_nettype wire

FILE: sv/ecf_ram.sv
`default_nettype none
module ecf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write one word, read one word through an output register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: sv/euler_cycle_finder_unit.sv
`default_nettype none
`include "assert_macros.svh"
// Euler circuit finder for an undirected graph of up to eight vertices.
// Command channel: a word (mode_i, edge_from_i, edge_to_i) is taken when
// start is high and busy is low; busy stays high until the command is done.
// Add edge: scans the first endpoint's neighbour list, a read and a compare
// step per entry, checks room in the second list, then writes both lists;
// a duplicate or a full list ends it sooner, and an endpoint out of range
// drops the word without raising busy. Clear: empties the lists, no busy.
// Find: a breadth-first pass from vertex 0 (a read and a compare step per
// list entry plus a pop step per vertex), a degree pass (a check step per
// vertex), then a depth-first edge walk (scan, compare and mark steps per
// list entry visited, and an emit and a load step per pop). The walk waits
// for the wipe of the edge marks that starts with the find.
// All of it runs one step a cycle.
// Results come as one-cycle strobes on result_valid_o with cycle_vertex_o,
// found_o and last_o; the receiver cannot stall them. A failed find gives
// one word with found_o low and last_o high.
// The APB port holds vertex_count at addresses 0 to 3; writing it empties the graph.
// Reset: vertex_count is 8, all lists are empty, the block is idle.
module euler_cycle_finder_unit
  import ecf_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [1:0]      mode_i,
  input  wire logic [VtxW-1:0] edge_from_i,
  input  wire logic [VtxW-1:0] edge_to_i,
  output logic                 result_valid_o,
  output logic [VtxW-1:0]      cycle_vertex_o,
  output logic                 found_o,
  output logic                 last_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  typedef enum logic [14:0] {
    StIdle  = 15'b000000000000001,
    StARd   = 15'b000000000000010,
    StACmp  = 15'b000000000000100,
    StACap  = 15'b000000000001000,
    StAWr1  = 15'b000000000010000,
    StAWr2  = 15'b000000000100000,
    StBInit = 15'b000000001000000,
    StBPop  = 15'b000000010000000,
    StBRd   = 15'b000000100000000,
    StBCmp  = 15'b000001000000000,
    StDChk  = 15'b000010000000000,
    StWScan = 15'b000100000000000,
    StWCmp  = 15'b001000000000000,
    StWLoad = 15'b010000000000000,
    StWUse  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic [VcW-1:0]  vc_q, vc_d;
  logic [LenW-1:0] len_q [MaxVertices];
  logic [LenW-1:0] len_d [MaxVertices];
  logic [MaxVertices-1:0] reached_q, reached_d;
  logic [VtxW-1:0] queue_q [MaxVertices];
  logic [LenW-1:0] head_q, head_d, tail_q, tail_d, cnt_q, cnt_d;
  logic [VcW-1:0]  dv_q, dv_d;
  logic [VtxW-1:0] a_q, a_d, b_q, b_d, v_q, v_d, cur_q, cur_d, nbr_q, nbr_d;
  logic [LenW-1:0] i_q, i_d, pos_q, pos_d;
  logic [SpW-1:0]  sp_q, sp_d;
  logic [ClrW-1:0] clr_q, clr_d;
  logic            rv_q, rv_d, fd_q, fd_d, ls_q, ls_d;
  logic [VtxW-1:0] cv_q, cv_d;

  logic            q_we;
  logic [VtxW-1:0] q_widx, q_wdata;

  logic [VtxW-1:0] len_idx;
  logic [LenW-1:0] len_rd;
  logic [LenW-1:0] pos_next;

  logic                       nb_we;
  logic [$clog2(NbrDepth)-1:0] nb_waddr, nb_raddr;
  logic [VtxW-1:0]            nb_wdata, nb_rdata;

  logic                          st_we;
  logic [$clog2(MaxResults)-1:0] st_waddr, st_raddr;
  logic [StkW-1:0]               st_wdata, st_rdata;

  logic              used_we;
  logic [UsedAw-1:0] used_waddr, used_raddr, pair_rd, pair_wr;
  logic              used_wdata, used_rdata;

  logic           cfg_wr;
  logic [VcW-1:0] cfg_val;

  ecf_ram #(.Width(VtxW), .Depth(NbrDepth)) u_nbr_ram (
    .clk_i  (clk_i),
    .we_i   (nb_we),
    .waddr_i(nb_waddr),
    .wdata_i(nb_wdata),
    .raddr_i(nb_raddr),
    .rdata_o(nb_rdata)
  );

  ecf_ram #(.Width(StkW), .Depth(MaxResults)) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  // One mark per vertex pair, lower vertex first
  ecf_ram #(.Width(1), .Depth(UsedDepth)) u_used_ram (
    .clk_i  (clk_i),
    .we_i   (used_we),
    .waddr_i(used_waddr),
    .wdata_i(used_wdata),
    .raddr_i(used_raddr),
    .rdata_o(used_rdata)
  );

  assign busy           = (state_q != StIdle);
  assign result_valid_o = rv_q;
  assign cycle_vertex_o = cv_q;
  assign found_o        = fd_q;
  assign last_o         = ls_q;
  assign pready         = 1'b1;
  assign prdata         = 32'(vc_q);
  assign pos_next       = pos_q + LenW'(1);
  assign pair_rd        = (cur_q < nb_rdata) ? {cur_q, nb_rdata} : {nb_rdata, cur_q};
  assign pair_wr        = (cur_q < nbr_q) ? {cur_q, nbr_q} : {nbr_q, cur_q};

  // Decode a register write and clamp the vertex count to 1..8
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  always_comb begin
    cfg_val = pwdata[VcW-1:0];
    if (cfg_val == '0) begin
      cfg_val = VcW'(1);
    end else if (cfg_val > VcW'(MaxVertices)) begin
      cfg_val = VcW'(MaxVertices);
    end
  end

  // Pick the one list length each step needs
  always_comb begin
    case (state_q)
      StACap, StAWr2: len_idx = b_q;
      StBRd:          len_idx = v_q;
      StDChk:         len_idx = dv_q[VtxW-1:0];
      StWScan:        len_idx = cur_q;
      default:        len_idx = a_q;
    endcase
  end
  assign len_rd = len_q[len_idx];

  // Sequencer
  always_comb begin
    state_d    = state_q;
    vc_d       = vc_q;
    len_d      = len_q;
    reached_d  = reached_q;
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    dv_d       = dv_q;
    a_d        = a_q;
    b_d        = b_q;
    v_d        = v_q;
    cur_d      = cur_q;
    nbr_d      = nbr_q;
    i_d        = i_q;
    pos_d      = pos_q;
    sp_d       = sp_q;
    clr_d      = clr_q;
    rv_d       = 1'b0;
    cv_d       = cv_q;
    fd_d       = fd_q;
    ls_d       = ls_q;
    q_we       = 1'b0;
    q_widx     = '0;
    q_wdata    = '0;
    nb_we      = 1'b0;
    nb_waddr   = '0;
    nb_wdata   = '0;
    nb_raddr   = '0;
    st_we      = 1'b0;
    st_waddr   = '0;
    st_wdata   = '0;
    st_raddr   = '0;
    used_we    = 1'b0;
    used_waddr = '0;
    used_wdata = 1'b0;
    used_raddr = '0;

    // Wipe the edge marks one word a cycle
    if (!clr_q[UsedAw]) begin
      used_we    = 1'b1;
      used_waddr = clr_q[UsedAw-1:0];
      used_wdata = 1'b0;
      clr_d      = clr_q + ClrW'(1);
    end

    case (state_q)
      StIdle: begin
        if (start) begin
          case (mode_i)
            ModeAdd: begin
              a_d = edge_from_i;
              b_d = edge_to_i;
              i_d = '0;
              if ((VcW'(edge_from_i) < vc_q) && (VcW'(edge_to_i) < vc_q)) begin
                state_d = StARd;
              end
            end
            ModeFind: state_d = StBInit;
            ModeClear: begin
              for (int k = 0; k < MaxVertices; k++) len_d[k] = '0;
            end
            default: ;
          endcase
        end
      end
      // Scan the first endpoint's list for a duplicate; drop the edge if it is full
      StARd: begin
        if (i_q < len_rd) begin
          nb_raddr = {a_q, i_q};
          state_d  = StACmp;
        end else if (len_rd >= LenW'(ListCap)) begin
          state_d = StIdle;
        end else begin
          state_d = StACap;
        end
      end
      StACmp: begin
        if (nb_rdata == b_q) begin
          state_d = StIdle;
        end else begin
          i_d     = i_q + LenW'(1);
          state_d = StARd;
        end
      end
      // Drop the edge if the second list has no room
      StACap: begin
        if ((a_q == b_q) ? (len_rd >= LenW'(ListCap - 1)) : (len_rd >= LenW'(ListCap))) begin
          state_d = StIdle;
        end else begin
          state_d = StAWr1;
        end
      end
      StAWr1: begin
        nb_we      = 1'b1;
        nb_waddr   = {a_q, len_rd};
        nb_wdata   = b_q;
        len_d[a_q] = len_rd + LenW'(1);
        state_d    = StAWr2;
      end
      StAWr2: begin
        nb_we      = 1'b1;
        nb_waddr   = {b_q, len_rd};
        nb_wdata   = a_q;
        len_d[b_q] = len_rd + LenW'(1);
        state_d    = StIdle;
      end
      // Breadth-first reachability from vertex 0; start the mark wipe
      StBInit: begin
        reached_d    = '0;
        reached_d[0] = 1'b1;
        q_we         = 1'b1;
        head_d       = '0;
        tail_d       = LenW'(1);
        cnt_d        = '0;
        clr_d        = '0;
        state_d      = StBPop;
      end
      StBPop: begin
        if (head_q < tail_q) begin
          v_d     = queue_q[head_q[VtxW-1:0]];
          head_d  = head_q + LenW'(1);
          cnt_d   = cnt_q + LenW'(1);
          i_d     = '0;
          state_d = StBRd;
        end else if (VcW'(cnt_q) == vc_q) begin
          dv_d    = '0;
          state_d = StDChk;
        end else begin
          rv_d    = 1'b1;
          cv_d    = '0;
          fd_d    = 1'b0;
          ls_d    = 1'b1;
          state_d = StIdle;
        end
      end
      StBRd: begin
        if (i_q < len_rd) begin
          nb_raddr = {v_q, i_q};
          state_d  = StBCmp;
        end else begin
          state_d = StBPop;
        end
      end
      StBCmp: begin
        if (!reached_q[nb_rdata] && (tail_q < LenW'(MaxVertices))) begin
          reached_d[nb_rdata] = 1'b1;
          q_we                = 1'b1;
          q_widx              = tail_q[VtxW-1:0];
          q_wdata             = nb_rdata;
          tail_d              = tail_q + LenW'(1);
        end
        i_d     = i_q + LenW'(1);
        state_d = StBRd;
      end
      // Every degree must be even; hold until the marks are wiped
      StDChk: begin
        if (dv_q == vc_q) begin
          if (clr_q[UsedAw]) begin
            cur_d   = '0;
            pos_d   = '0;
            sp_d    = SpW'(1);
            state_d = StWScan;
          end
        end else if (len_rd[0]) begin
          rv_d    = 1'b1;
          cv_d    = '0;
          fd_d    = 1'b0;
          ls_d    = 1'b1;
          state_d = StIdle;
        end else begin
          dv_d = dv_q + VcW'(1);
        end
      end
      // Edge walk: fetch the next neighbour or emit and pop
      StWScan: begin
        if (pos_q < len_rd) begin
          nb_raddr = {cur_q, pos_q};
          state_d  = StWCmp;
        end else begin
          rv_d = 1'b1;
          cv_d = cur_q;
          fd_d = 1'b1;
          ls_d = (sp_q == SpW'(1));
          sp_d = sp_q - SpW'(1);
          if (sp_q == SpW'(1)) begin
            state_d = StIdle;
          end else begin
            st_raddr = $clog2(MaxResults)'(sp_q - SpW'(2));
            state_d  = StWLoad;
          end
        end
      end
      // Look up the mark of the edge to the fetched neighbour
      StWCmp: begin
        nbr_d      = nb_rdata;
        used_raddr = pair_rd;
        state_d    = StWUse;
      end
      StWUse: begin
        if (!used_rdata && (sp_q < SpW'(MaxResults))) begin
          used_we    = 1'b1;
          used_waddr = pair_wr;
          used_wdata = 1'b1;
          st_we      = 1'b1;
          st_waddr   = $clog2(MaxResults)'(sp_q - SpW'(1));
          st_wdata   = {cur_q, pos_next};
          cur_d      = nbr_q;
          pos_d      = '0;
          sp_d       = sp_q + SpW'(1);
        end else begin
          pos_d = pos_next;
        end
        state_d = StWScan;
      end
      StWLoad: begin
        cur_d   = st_rdata[StkW-1:LenW];
        pos_d   = st_rdata[LenW-1:0];
        state_d = StWScan;
      end
      default: state_d = StIdle;
    endcase

    // A register write empties the graph
    if (cfg_wr) begin
      vc_d = cfg_val;
      for (int k = 0; k < MaxVertices; k++) len_d[k] = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      vc_q      <= VcW'(MaxVertices);
      for (int k = 0; k < MaxVertices; k++) len_q[k] <= '0;
      reached_q <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      dv_q      <= '0;
      i_q       <= '0;
      pos_q     <= '0;
      sp_q      <= '0;
      clr_q     <= '0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      vc_q      <= vc_d;
      len_q     <= len_d;
      reached_q <= reached_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      dv_q      <= dv_d;
      i_q       <= i_d;
      pos_q     <= pos_d;
      sp_q      <= sp_d;
      clr_q     <= clr_d;
      rv_q      <= rv_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    v_q   <= v_d;
    cur_q <= cur_d;
    nbr_q <= nbr_d;
    cv_q  <= cv_d;
    fd_q  <= fd_d;
    ls_q  <= ls_d;
    if (q_we) begin
      queue_q[q_widx] <= q_wdata;
    end
  end

  `ECF_ASSERT(a_fail_word, rv_q && !fd_q |-> (cv_q == '0) && ls_q, "failed find word malformed")
  `ECF_ASSERT(a_last_idle, rv_q && ls_q |-> !busy, "busy after last word")
  `ECF_ASSERT_NEXT(a_find_busy, start && !busy && (mode_i == ModeFind), busy, "find not started")
  `ECF_ASSERT(a_sp_bound, sp_q <= SpW'(MaxResults), "walk stack overflow")

endmodule
`default_nettype wire
